@@ src/lpcrc_pkg.sv @@
// lpcrc_pkg: shared types and constants of the q15 prediction residual codec
// no dependencies; imported by lpcrc_coef_store and lpc_residual_codec_q15_core
`timescale 1ns / 1ps
`default_nettype none
package lpcrc_pkg;

	localparam int Q_SHIFT    = 15;
	localparam int COEF_W     = 16;
	localparam int SAMPLE_W   = 32;
	localparam int ORDER_W    = 6;
	localparam int HEAD_W     = 5;
	localparam int PROD_W     = COEF_W + SAMPLE_W;
	localparam int ACC_W      = PROD_W + 6;
	localparam int PRED_W     = ACC_W - Q_SHIFT;
	localparam int SUM_W      = PRED_W + 1;

	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	localparam logic REG_DECODE_MODE  = 1'b0;
	localparam logic REG_FILTER_ORDER = 1'b1;

	localparam logic [ORDER_W-1:0] ORDER_RESET = 6'd32;

	typedef struct packed {
		logic                     en;
		logic [ORDER_W-1:0]       idx;
		logic signed [COEF_W-1:0] data;
	} coef_wr_t;

endpackage
`default_nettype wire

@@ src/lpc_residual_codec_q15_core.sv @@
// lpc_residual_codec_q15_core: top level of the q15 prediction residual codec
// depends on lpcrc_pkg and lpcrc_coef_store
//
// A coefficient load request is written to the coefficient store as it is
// accepted. A sample request runs one multiply-accumulate per tap through the
// history memory read port, with reads, product and accumulator registered in
// turn, then passes a sum state and a write-back state to the result register;
// taps is the smaller of the filter order and the samples held in the current
// block. A new request is accepted only after the previous sample has been
// written to the result register; the result may wait there while loads and
// the next sample proceed. Coefficients never written read as zero through
// per-tap valid bits, so no clearing pass follows reset. decode_mode and
// filter_order are meant to be written while the block is idle.
`timescale 1ns / 1ps
`default_nettype none
module lpc_residual_codec_q15_core #(
	parameter int MAX_ORDER = 32
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  psel,
	input  wire                                  penable,
	input  wire                                  pwrite,
	input  wire  [2:0]                           paddr,
	input  wire  [31:0]                          pwdata,
	output logic [31:0]                          prdata,
	output logic                                 pready,
	input  wire                                  in_valid,
	output logic                                 in_ready,
	input  wire                                  opcode,
	input  wire  [lpcrc_pkg::ORDER_W-1:0]        coeff_index,
	input  wire  signed [lpcrc_pkg::COEF_W-1:0]  coeff_value,
	input  wire  signed [lpcrc_pkg::SAMPLE_W-1:0] sample_value,
	input  wire                                  block_start,
	output logic                                 out_valid,
	input  wire                                  out_ready,
	output logic signed [lpcrc_pkg::SAMPLE_W-1:0] out_value,
	output logic                                 saturated
);
	import lpcrc_pkg::*;

	localparam int CW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
	localparam int RING_DEPTH = 2 ** HEAD_W;
	localparam logic [ORDER_W-1:0] MAX_ORD = ORDER_W'(MAX_ORDER);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_SUM  = 2'd2;
	localparam logic [1:0] ST_WB   = 2'd3;

	// configuration
	logic               decode_mode_q;
	logic [ORDER_W-1:0] filter_order_q;
	logic               cfg_we;

	// control
	logic [1:0]         state_q;
	logic [ORDER_W-1:0] taps_q;
	logic [ORDER_W-1:0] cnt_q;
	logic [ORDER_W-1:0] fill_q;
	logic [HEAD_W-1:0]  head_q;
	logic               in_fire;
	logic               smp_fire;
	logic               issue;
	logic               wb_fire;
	logic [ORDER_W-1:0] order_eff;
	logic [ORDER_W-1:0] fill_eff;
	logic [HEAD_W-1:0]  hist_rd_addr;

	// datapath
	logic signed [SAMPLE_W-1:0] hist_mem [RING_DEPTH];
	logic signed [SAMPLE_W-1:0] hist_s1;
	logic signed [COEF_W-1:0]   coef_s1;
	logic                       vld_s1;
	logic signed [PROD_W-1:0]   prod_s2;
	logic                       vld_s2;
	logic signed [ACC_W-1:0]    acc_q;
	logic signed [SAMPLE_W-1:0] x_q;
	logic signed [SUM_W-1:0]    sum_q;
	logic signed [ACC_W-1:0]    acc_sh;
	logic signed [PRED_W-1:0]   pred;
	logic signed [PRED_W-1:0]   x_ext;
	logic                       sat_hi;
	logic                       sat_lo;
	logic signed [SAMPLE_W-1:0] clamped;
	coef_wr_t                   coef_wr;

	// result register
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] out_value_q;
	logic                       saturated_q;

	// configuration port
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decode_mode_q  <= 1'b0;
			filter_order_q <= ORDER_RESET;
		end else if (cfg_we) begin
			unique case (paddr[2])
				REG_DECODE_MODE:  decode_mode_q  <= pwdata[0];
				REG_FILTER_ORDER: filter_order_q <= pwdata[ORDER_W-1:0];
				default:          decode_mode_q  <= decode_mode_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_DECODE_MODE:  prdata = {31'b0, decode_mode_q};
			REG_FILTER_ORDER: prdata = {{(32-ORDER_W){1'b0}}, filter_order_q};
			default:          prdata = '0;
		endcase
	end

	// request handling
	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign smp_fire  = in_fire && (opcode == OP_SAMPLE);
	assign order_eff = (filter_order_q > MAX_ORD) ? MAX_ORD : filter_order_q;
	assign fill_eff  = block_start ? '0 : fill_q;
	assign issue     = (state_q == ST_RUN) && (cnt_q < taps_q);
	assign wb_fire   = (state_q == ST_WB) && (!out_valid_q || out_ready);
	assign hist_rd_addr = head_q - cnt_q[HEAD_W-1:0] - HEAD_W'(1);

	assign coef_wr.en   = in_fire && (opcode == OP_LOAD);
	assign coef_wr.idx  = coeff_index;
	assign coef_wr.data = coeff_value;

	lpcrc_coef_store #(
		.MAX_ORDER (MAX_ORDER),
		.CW        (CW)
	) u_coef (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (coef_wr),
		.rd_en   (issue),
		.rd_addr (cnt_q[CW-1:0]),
		.rd_data (coef_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			taps_q  <= '0;
			cnt_q   <= '0;
			fill_q  <= '0;
			head_q  <= '0;
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
		end else begin
			vld_s1 <= issue;
			vld_s2 <= vld_s1;
			unique case (state_q)
				ST_IDLE: begin
					if (smp_fire) begin
						taps_q  <= (order_eff < fill_eff) ? order_eff : fill_eff;
						cnt_q   <= '0;
						if (block_start) begin
							fill_q <= '0;
						end
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (issue) begin
						cnt_q <= cnt_q + ORDER_W'(1);
					end else if (!vld_s1 && !vld_s2) begin
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					state_q <= ST_WB;
				end
				ST_WB: begin
					if (wb_fire) begin
						head_q  <= head_q + HEAD_W'(1);
						if (fill_q < MAX_ORD) begin
							fill_q <= fill_q + ORDER_W'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// history ring: read per tap, written once per sample after all reads
	always_ff @(posedge clk) begin
		if (issue) begin
			hist_s1 <= hist_mem[hist_rd_addr];
		end
		if (wb_fire) begin
			hist_mem[head_q] <= decode_mode_q ? clamped : x_q;
		end
	end

	// multiply-accumulate
	assign acc_sh = acc_q >>> Q_SHIFT;
	assign pred   = acc_sh[PRED_W-1:0];
	assign x_ext  = {{(PRED_W-SAMPLE_W){x_q[SAMPLE_W-1]}}, x_q};

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			prod_s2 <= coef_s1 * hist_s1;
		end
		if (smp_fire) begin
			x_q   <= sample_value;
			acc_q <= '0;
		end else if (vld_s2) begin
			acc_q <= acc_q + {{(ACC_W-PROD_W){prod_s2[PROD_W-1]}}, prod_s2};
		end
		if (state_q == ST_SUM) begin
			if (decode_mode_q) begin
				sum_q <= {pred[PRED_W-1], pred} + {x_ext[PRED_W-1], x_ext};
			end else begin
				sum_q <= {x_ext[PRED_W-1], x_ext} - {pred[PRED_W-1], pred};
			end
		end
	end

	// clamp to 32 bits
	assign sat_hi = !sum_q[SUM_W-1] && (|sum_q[SUM_W-2:SAMPLE_W-1]);
	assign sat_lo = sum_q[SUM_W-1] && !(&sum_q[SUM_W-2:SAMPLE_W-1]);

	always_comb begin
		priority if (sat_hi) begin
			clamped = {1'b0, {(SAMPLE_W-1){1'b1}}};
		end else if (sat_lo) begin
			clamped = {1'b1, {(SAMPLE_W-1){1'b0}}};
		end else begin
			clamped = sum_q[SAMPLE_W-1:0];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (wb_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wb_fire) begin
			out_value_q <= clamped;
			saturated_q <= sat_hi || sat_lo;
		end
	end

	assign out_valid = out_valid_q;
	assign out_value = out_value_q;
	assign saturated = saturated_q;

	// checks
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= taps_q)
		else $error("tap counter ran past tap count");

	a_pipe_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SUM) |-> (!vld_s1 && !vld_s2))
		else $error("sum started with products in flight");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= MAX_ORD)
		else $error("history fill above max order");

	a_head_step: assert property (@(posedge clk) disable iff (!arst_n)
		wb_fire |=> (head_q == $past(head_q) + HEAD_W'(1)) && out_valid_q)
		else $error("history write without head advance or result");

endmodule
`default_nettype wire

@@ src/lpcrc_coef_store.sv @@
// lpcrc_coef_store: coefficient memory with per-tap valid bits, one registered read port
// depends on lpcrc_pkg
`timescale 1ns / 1ps
`default_nettype none
module lpcrc_coef_store #(
	parameter int MAX_ORDER = 32,
	parameter int CW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1
) (
	input  wire                                        clk,
	input  wire                                        arst_n,
	input  lpcrc_pkg::coef_wr_t                        wr,
	input  wire                                        rd_en,
	input  wire  [CW-1:0]                              rd_addr,
	output logic signed [lpcrc_pkg::COEF_W-1:0]        rd_data
);
	import lpcrc_pkg::*;

	localparam logic [ORDER_W-1:0] MAX_ORD = ORDER_W'(MAX_ORDER);

	logic signed [COEF_W-1:0] mem [MAX_ORDER];
	logic [MAX_ORDER-1:0]     vld_q;
	logic signed [COEF_W-1:0] mem_rd_q;
	logic                     vld_rd_q;
	logic                     wr_ok;
	logic [ORDER_W-1:0]       wr_tap;

	// taps outside 1..MAX_ORDER are dropped
	assign wr_ok  = wr.en && (wr.idx != '0) && (wr.idx <= MAX_ORD);
	assign wr_tap = wr.idx - ORDER_W'(1);

	always_ff @(posedge clk) begin
		if (wr_ok) begin
			mem[wr_tap[CW-1:0]] <= wr.data;
		end
		if (rd_en) begin
			mem_rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			vld_rd_q <= 1'b0;
		end else begin
			if (wr_ok) begin
				vld_q[wr_tap[CW-1:0]] <= 1'b1;
			end
			if (rd_en) begin
				vld_rd_q <= vld_q[rd_addr];
			end
		end
	end

	// never-written taps read as zero
	assign rd_data = vld_rd_q ? mem_rd_q : '0;

endmodule
`default_nettype wire
